// ----- src/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Each macro expands to one labeled concurrent assertion on clk, reset by rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property every clock while out of reset.
`define CHK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a cause implies an effect on the next clock.
`define CHK_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);
`endif

// ----- src/hcb_pkg.sv -----
// Shared types and codes for the static Huffman engine.
// No dependencies.
`default_nettype none
package hcb_pkg;
    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_COUNT  = 3'd1,
        OP_BUILD  = 3'd2,
        OP_ENCODE = 3'd3,
        OP_DECODE = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DECODED  = 3'd1,
        ST_UNKNOWN  = 3'd2,
        ST_BAD_WALK = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_NO_TREE  = 3'd5
    } status_t;
endpackage
`default_nettype wire

// ----- src/huffman_code_builder_codec.sv -----
// Static Huffman engine for a byte alphabet, one operation per transfer.
// Depends on hcb_pkg and hcb_ram.
//
// Usage: present operation, symbol and code_bit with start high while busy
// is low. The transfer's single result appears on status, decoded_symbol,
// code_value, code_length and distinct_symbols for one cycle with done high.
// The receiver cannot stall; results are never held.
// Steps: clear zeroes the histogram, one entry per cycle. Count reads and
// increments one histogram entry (saturating), encode reads the code table and
// decode follows one tree edge; unused operation codes finish straight from
// idle. Build clears the code table and makes a leaf pass, then runs N-1
// merges for N distinct symbols (each merge scans the nodes built so far twice
// through the shared compare unit, one node a cycle), then walks the tree.
// busy stays high throughout; the next transfer can be taken in the cycle
// that done is high, so one operation runs at a time.
// Reset: a clearing pass over all ALPHABET_SIZE entries zeroes the histogram
// and code lengths; busy is high until it ends. The tree is invalid after reset.
`default_nettype none
module huffman_code_builder_codec
    import hcb_pkg::*;
#(
    parameter int ALPHABET_SIZE = 256,
    parameter int COUNT_BITS    = 16,
    parameter int MAX_CODE_BITS = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    output logic            done,
    input  wire logic [2:0] operation,
    input  wire logic [7:0] symbol,
    input  wire logic       code_bit,
    output logic [2:0]      status,
    output logic [7:0]      decoded_symbol,
    output logic [31:0]     code_value,
    output logic [5:0]      code_length,
    output logic [8:0]      distinct_symbols
);
    localparam int NODES = 2 * ALPHABET_SIZE - 1;
    localparam int NB    = $clog2(NODES + 1);
    localparam int SB    = $clog2(ALPHABET_SIZE);
    localparam int WB    = COUNT_BITS + SB;
    localparam int LB    = $clog2(MAX_CODE_BITS + 2);
    localparam logic [NB-1:0] NO_CHILD = {NB{1'b1}};
    localparam logic [COUNT_BITS-1:0] LIMIT = {COUNT_BITS{1'b1}};

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_CLR, S_CNT_RD, S_CNT_WAIT, S_CNT_WR,
        S_ENC_WAIT, S_ENC_OUT, S_DEC_WAIT, S_DEC_OUT,
        S_B_TCLR, S_B_LEAF_RD, S_B_LEAF, S_B_SCAN_RD, S_B_SCAN, S_B_MERGE,
        S_B_SINGLE, S_W_POP, S_W_WAIT, S_W_NODE, S_W_DONE
    } state_t;

    state_t state_reg;

    // histogram
    logic                  cnt_we;
    logic [SB-1:0]         cnt_wa, cnt_ra;
    logic [COUNT_BITS-1:0] cnt_wd, cnt_rd;
    hcb_ram #(.WIDTH(COUNT_BITS), .DEPTH(ALPHABET_SIZE)) u_cnt (
        .clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd),
        .raddr(cnt_ra), .rdata(cnt_rd));

    // node store: weight, left, right
    localparam int NW = WB + 2 * NB;
    logic          nd_we;
    logic [NB-1:0] nd_wa, nd_ra;
    logic [NW-1:0] nd_wd, nd_rd;
    hcb_ram #(.WIDTH(NW), .DEPTH(2 ** NB)) u_node (
        .clk(clk), .we(nd_we), .waddr(nd_wa), .wdata(nd_wd),
        .raddr(nd_ra), .rdata(nd_rd));

    // live flags of the node store, read at the node store address
    logic          lv_we;
    logic [NB-1:0] lv_wa;
    logic          lv_wd, lv_rd;
    hcb_ram #(.WIDTH(1), .DEPTH(2 ** NB)) u_live (
        .clk(clk), .we(lv_we), .waddr(lv_wa), .wdata(lv_wd),
        .raddr(nd_ra), .rdata(lv_rd));

    // leaf symbols
    logic          lf_we;
    logic [SB-1:0] lf_wa, lf_ra;
    logic [SB-1:0] lf_wd, lf_rd;
    hcb_ram #(.WIDTH(SB), .DEPTH(ALPHABET_SIZE)) u_leaf (
        .clk(clk), .we(lf_we), .waddr(lf_wa), .wdata(lf_wd),
        .raddr(lf_ra), .rdata(lf_rd));

    // code table: code, length
    localparam int TW = MAX_CODE_BITS + LB;
    logic          tb_we;
    logic [SB-1:0] tb_wa, tb_ra;
    logic [TW-1:0] tb_wd, tb_rd;
    hcb_ram #(.WIDTH(TW), .DEPTH(ALPHABET_SIZE)) u_tab (
        .clk(clk), .we(tb_we), .waddr(tb_wa), .wdata(tb_wd),
        .raddr(tb_ra), .rdata(tb_rd));

    // code walk stack
    localparam int KW = NB + MAX_CODE_BITS + LB + 1;
    logic          sk_we;
    logic [NB-1:0] sk_wa, sk_ra;
    logic [KW-1:0] sk_wd, sk_rd;
    hcb_ram #(.WIDTH(KW), .DEPTH(2 ** NB)) u_stk (
        .clk(clk), .we(sk_we), .waddr(sk_wa), .wdata(sk_wd),
        .raddr(sk_ra), .rdata(sk_rd));

    logic [NB-1:0]  idx_reg, total_reg, n_reg, root_reg, walk_reg, best_reg, a_reg;
    logic [NB-1:0]  sp_reg;
    logic [WB-1:0]  bestw_reg, aw_reg;
    logic           found_reg, second_reg, tree_reg, kid_reg;
    logic [7:0]     sym_reg;
    logic           bit_reg;
    logic [NB-1:0]  cur_reg;
    logic [MAX_CODE_BITS-1:0] wcode_reg;
    logic [LB-1:0]  wlen_reg;
    logic           wover_reg;

    logic [WB-1:0] rd_w;
    logic [NB-1:0] rd_l, rd_r;
    assign rd_w = nd_rd[NW-1 -: WB];
    assign rd_l = nd_rd[2*NB-1 -: NB];
    assign rd_r = nd_rd[NB-1:0];

    logic sym_ok;
    assign sym_ok = ({1'b0, sym_reg} < 9'(ALPHABET_SIZE));

    // stack entry fields
    logic [NB-1:0]            sk_node;
    logic [MAX_CODE_BITS-1:0] sk_code;
    logic [LB-1:0]            sk_len;
    logic                     sk_over;
    assign {sk_node, sk_code, sk_len, sk_over} = sk_rd;

    logic [LB-1:0] len_inc;
    logic          ch_over;
    assign len_inc = wlen_reg + LB'(1);
    assign ch_over = wover_reg || (len_inc > LB'(MAX_CODE_BITS));

    // shared compare unit: is the scanned node lighter than the best so far
    logic lighter;
    assign lighter = !found_reg || (rd_w < bestw_reg);

    always_comb
    begin
        cnt_we = 1'b0; cnt_wa = idx_reg[SB-1:0]; cnt_wd = '0;
        cnt_ra = sym_reg[SB-1:0];
        nd_we = 1'b0; nd_wa = total_reg; nd_wd = '0; nd_ra = idx_reg;
        lv_we = 1'b0; lv_wa = n_reg; lv_wd = 1'b1;
        lf_we = 1'b0; lf_wa = n_reg[SB-1:0]; lf_wd = idx_reg[SB-1:0];
        lf_ra = sym_reg[SB-1:0];
        tb_we = 1'b0; tb_wa = idx_reg[SB-1:0]; tb_wd = '0; tb_ra = sym_reg[SB-1:0];
        sk_we = 1'b0; sk_wa = sp_reg; sk_wd = '0; sk_ra = sp_reg - NB'(1);
        unique case (state_reg)
            S_INIT:
            begin
                cnt_we = 1'b1; tb_we = 1'b1;
            end
            S_CLR: cnt_we = 1'b1;
            S_CNT_RD: cnt_ra = sym_reg[SB-1:0];
            S_CNT_WR:
            begin
                cnt_wa = sym_reg[SB-1:0];
                cnt_wd = cnt_rd + COUNT_BITS'(1);
                cnt_we = sym_ok && (cnt_rd != LIMIT);
            end
            S_B_TCLR: tb_we = 1'b1;
            S_B_LEAF_RD: cnt_ra = idx_reg[SB-1:0];
            S_B_LEAF:
            begin
                cnt_ra = idx_reg[SB-1:0] + SB'(1);
                if (cnt_rd != '0)
                begin
                    nd_we = 1'b1; nd_wa = n_reg;
                    nd_wd = {WB'(cnt_rd), NO_CHILD, NO_CHILD};
                    lf_we = 1'b1;
                    lv_we = 1'b1;
                end
            end
            S_B_SCAN_RD: nd_ra = idx_reg;
            S_B_SCAN:
            begin
                nd_ra = idx_reg + NB'(1);
                // drop the pick from the live set at the end of the scan
                if (idx_reg == total_reg - NB'(1))
                begin
                    lv_we = 1'b1; lv_wd = 1'b0;
                    lv_wa = (lv_rd && lighter) ? idx_reg : best_reg;
                end
            end
            S_B_MERGE:
            begin
                nd_we = 1'b1; nd_wa = total_reg;
                nd_wd = {aw_reg + bestw_reg, a_reg, best_reg};
                lv_we = 1'b1; lv_wa = total_reg;
                if (total_reg == NB'(2) * n_reg - NB'(2))
                begin
                    // seed the code walk with the root
                    sk_we = 1'b1; sk_wa = '0;
                    sk_wd = {total_reg, MAX_CODE_BITS'(0), LB'(0), 1'b0};
                end
            end
            S_B_SINGLE:
            begin
                nd_we = 1'b1; nd_wa = NB'(1);
                nd_wd = {aw_reg, NB'(0), NO_CHILD};
                sk_we = 1'b1; sk_wa = '0;
                sk_wd = {NB'(1), MAX_CODE_BITS'(0), LB'(0), 1'b0};
            end
            S_W_POP: sk_ra = sp_reg - NB'(1);
            S_W_WAIT:
            begin
                nd_ra = sk_node; lf_ra = sk_node[SB-1:0];
            end
            S_W_NODE:
            begin
                nd_ra = cur_reg; lf_ra = cur_reg[SB-1:0];
                if (cur_reg < n_reg)
                begin
                    if (!wover_reg && wlen_reg != '0)
                    begin
                        tb_we = 1'b1; tb_wa = lf_rd;
                        tb_wd = {wcode_reg, wlen_reg};
                    end
                end
                else
                begin
                    // push the right child first, then the left
                    sk_we = 1'b1;
                    sk_wd = kid_reg == 1'b0
                        ? {rd_r, ch_over ? MAX_CODE_BITS'(0)
                                         : {wcode_reg[MAX_CODE_BITS-2:0], 1'b1},
                           len_inc, ch_over}
                        : {rd_l, ch_over ? MAX_CODE_BITS'(0)
                                         : {wcode_reg[MAX_CODE_BITS-2:0], 1'b0},
                           len_inc, ch_over};
                    if ((kid_reg ? rd_l : rd_r) == NO_CHILD)
                    begin
                        sk_we = 1'b0;
                    end
                end
            end
            S_ENC_WAIT: tb_ra = sym_reg[SB-1:0];
            S_DEC_WAIT:
            begin
                nd_ra = walk_reg;
                lf_ra = '0;
            end
            S_DEC_OUT:
            begin
                nd_ra = walk_reg;
                lf_ra = (bit_reg ? rd_r[SB-1:0] : rd_l[SB-1:0]);
            end
            default: ;
        endcase
    end

    logic [NB-1:0] nxt_child;
    assign nxt_child = bit_reg ? rd_r : rd_l;
    logic dec_pend_reg;
    logic [NB-1:0] dec_nxt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            idx_reg <= '0;
            busy <= 1'b1;
            done <= 1'b0;
            tree_reg <= 1'b0;
            walk_reg <= '0;
            dec_pend_reg <= 1'b0;
            status <= '0; decoded_symbol <= '0; code_value <= '0;
            code_length <= '0; distinct_symbols <= '0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_INIT:
                begin
                    idx_reg <= idx_reg + NB'(1);
                    if (idx_reg == NB'(ALPHABET_SIZE - 1))
                    begin
                        state_reg <= S_IDLE; busy <= 1'b0;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        busy <= 1'b1;
                        sym_reg <= symbol; bit_reg <= code_bit;
                        status <= ST_OK; decoded_symbol <= '0; code_value <= '0;
                        code_length <= '0; distinct_symbols <= '0;
                        idx_reg <= '0;
                        case (operation)
                            OP_CLEAR: state_reg <= S_CLR;
                            OP_COUNT: state_reg <= S_CNT_RD;
                            OP_BUILD: state_reg <= S_B_TCLR;
                            OP_ENCODE: state_reg <= S_ENC_WAIT;
                            OP_DECODE: state_reg <= S_DEC_WAIT;
                            default:
                            begin
                                done <= 1'b1; busy <= 1'b0;
                            end
                        endcase
                    end
                end
                S_CLR:
                begin
                    idx_reg <= idx_reg + NB'(1);
                    if (idx_reg == NB'(ALPHABET_SIZE - 1))
                    begin
                        done <= 1'b1; busy <= 1'b0; state_reg <= S_IDLE;
                    end
                end
                S_CNT_RD: state_reg <= S_CNT_WAIT;
                S_CNT_WAIT: state_reg <= S_CNT_WR;
                S_CNT_WR:
                begin
                    if (!sym_ok) status <= ST_UNKNOWN;
                    else if (cnt_rd == LIMIT) status <= ST_OVERFLOW;
                    done <= 1'b1; busy <= 1'b0; state_reg <= S_IDLE;
                end
                S_ENC_WAIT: state_reg <= S_ENC_OUT;
                S_ENC_OUT:
                begin
                    if (!tree_reg) status <= ST_NO_TREE;
                    else if (!sym_ok || tb_rd[LB-1:0] == '0) status <= ST_UNKNOWN;
                    else
                    begin
                        code_value <= 32'(tb_rd[TW-1 -: MAX_CODE_BITS]);
                        code_length <= 6'(tb_rd[LB-1:0]);
                    end
                    done <= 1'b1; busy <= 1'b0; state_reg <= S_IDLE;
                end
                S_DEC_WAIT:
                begin
                    state_reg <= S_DEC_OUT;
                    dec_pend_reg <= 1'b0;
                end
                S_DEC_OUT:
                begin
                    if (!tree_reg)
                    begin
                        status <= ST_NO_TREE;
                        done <= 1'b1; busy <= 1'b0; state_reg <= S_IDLE;
                    end
                    else if (!dec_pend_reg)
                    begin
                        // let the registered leaf symbol read of the chosen child complete
                        dec_pend_reg <= 1'b1;
                        dec_nxt_reg <= nxt_child;
                    end
                    else
                    begin
                        if (dec_nxt_reg == NO_CHILD)
                        begin
                            status <= ST_BAD_WALK; walk_reg <= root_reg;
                        end
                        else if (dec_nxt_reg < n_reg)
                        begin
                            status <= ST_DECODED;
                            decoded_symbol <= 8'(lf_rd);
                            walk_reg <= root_reg;
                        end
                        else walk_reg <= dec_nxt_reg;
                        done <= 1'b1; busy <= 1'b0; state_reg <= S_IDLE;
                    end
                end
                S_B_TCLR:
                begin
                    idx_reg <= idx_reg + NB'(1);
                    if (idx_reg == NB'(ALPHABET_SIZE - 1))
                    begin
                        idx_reg <= '0; n_reg <= '0; state_reg <= S_B_LEAF_RD;
                    end
                end
                S_B_LEAF_RD: state_reg <= S_B_LEAF;
                S_B_LEAF:
                begin
                    if (cnt_rd != '0)
                    begin
                        n_reg <= n_reg + NB'(1);
                        aw_reg <= WB'(cnt_rd);
                    end
                    idx_reg <= idx_reg + NB'(1);
                    if (idx_reg == NB'(ALPHABET_SIZE - 1))
                    begin
                        distinct_symbols <= 9'(n_reg + NB'(cnt_rd != '0));
                        total_reg <= n_reg + NB'(cnt_rd != '0);
                        idx_reg <= '0; found_reg <= 1'b0; second_reg <= 1'b0;
                        if (n_reg + NB'(cnt_rd != '0) == '0)
                        begin
                            tree_reg <= 1'b0; walk_reg <= '0; root_reg <= '0;
                            status <= ST_NO_TREE; distinct_symbols <= '0;
                            done <= 1'b1; busy <= 1'b0; state_reg <= S_IDLE;
                        end
                        else if (n_reg + NB'(cnt_rd != '0) == NB'(1))
                        begin
                            n_reg <= NB'(1);
                            state_reg <= S_B_SINGLE;
                        end
                        else
                        begin
                            n_reg <= n_reg + NB'(cnt_rd != '0);
                            state_reg <= S_B_SCAN_RD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_B_LEAF;
                    end
                end
                S_B_SINGLE:
                begin
                    root_reg <= NB'(1); sp_reg <= NB'(1);
                    state_reg <= S_W_POP;
                end
                S_B_SCAN_RD: state_reg <= S_B_SCAN;
                S_B_SCAN:
                begin
                    if (lv_rd && lighter)
                    begin
                        best_reg <= idx_reg; bestw_reg <= rd_w; found_reg <= 1'b1;
                    end
                    idx_reg <= idx_reg + NB'(1);
                    if (idx_reg == total_reg - NB'(1))
                    begin
                        // hold the first pick; the second stays in best_reg
                        if (!second_reg)
                        begin
                            if (lv_rd && lighter)
                            begin
                                a_reg <= idx_reg; aw_reg <= rd_w;
                            end
                            else
                            begin
                                a_reg <= best_reg; aw_reg <= bestw_reg;
                            end
                        end
                        idx_reg <= '0; found_reg <= 1'b0;
                        if (second_reg) state_reg <= S_B_MERGE;
                        else
                        begin
                            second_reg <= 1'b1; state_reg <= S_B_SCAN_RD;
                        end
                    end
                end
                S_B_MERGE:
                begin
                    // a_reg holds the first pick here; best_reg the second
                    total_reg <= total_reg + NB'(1);
                    second_reg <= 1'b0;
                    if (total_reg == NB'(2) * n_reg - NB'(2))
                    begin
                        root_reg <= total_reg;
                        sp_reg <= NB'(1);
                        state_reg <= S_W_POP;
                    end
                    else state_reg <= S_B_SCAN_RD;
                end
                S_W_POP:
                begin
                    if (sp_reg == '0) state_reg <= S_W_DONE;
                    else
                    begin
                        sp_reg <= sp_reg - NB'(1);
                        state_reg <= S_W_WAIT;
                    end
                end
                S_W_WAIT:
                begin
                    cur_reg <= sk_node; wcode_reg <= sk_code;
                    wlen_reg <= sk_len; wover_reg <= sk_over;
                    kid_reg <= 1'b0;
                    state_reg <= S_W_NODE;
                end
                S_W_NODE:
                begin
                    if (cur_reg < n_reg) state_reg <= S_W_POP;
                    else
                    begin
                        if ((kid_reg ? rd_l : rd_r) != NO_CHILD)
                            sp_reg <= sp_reg + NB'(1);
                        kid_reg <= 1'b1;
                        if (kid_reg) state_reg <= S_W_POP;
                    end
                end
                S_W_DONE:
                begin
                    tree_reg <= 1'b1; walk_reg <= root_reg;
                    done <= 1'b1; busy <= 1'b0; state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- src/hcb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- src/hcb_checker.sv -----
// Port-level checks for the Huffman engine, bound to the top level.
// Depends on assert_macros.svh and hcb_pkg.
`default_nettype none
`include "assert_macros.svh"
module hcb_checker
    import hcb_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [2:0] status,
    input wire logic [7:0] decoded_symbol,
    input wire logic [5:0] code_length
);
    `CHK_NEXT(a_take_busy, start && !busy, busy || done, "transfer not taken")
    `CHK_NEXT(a_done_pulse, done && !start, !done, "result strobe longer than a cycle")
    `CHK_ALWAYS(a_stat_range, !done || status <= ST_NO_TREE, "status out of range")
    `CHK_ALWAYS(a_dec_sym, !done || status == ST_DECODED || decoded_symbol == 8'd0,
        "decoded symbol without decode")
    `CHK_ALWAYS(a_len_range, !done || code_length <= 6'd32, "code length too long")
endmodule

bind huffman_code_builder_codec hcb_checker u_hcb_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .decoded_symbol(decoded_symbol), .code_length(code_length));
`default_nettype wire

// ----- tb/hcb_checker.sv -----
// Result checker for the static Huffman engine: predicts each transfer and compares results.
// Depends on hcb_pkg for the operation and status codes.
`default_nettype none
module hcb_result_checker
    import hcb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire logic       done,
    input  wire logic [2:0] operation,
    input  wire logic [7:0] symbol,
    input  wire logic       code_bit,
    input  wire logic [2:0] status,
    input  wire logic [7:0] decoded_symbol,
    input  wire logic [31:0] code_value,
    input  wire logic [5:0] code_length,
    input  wire logic [8:0] distinct_symbols,
    output int              errors,
    output int              checked,
    output int              pending
);
    localparam int NSYM = 256;
    localparam int NNODE = 2 * NSYM - 1;
    localparam int LIMIT = 65535;
    localparam int NONE = -1;
    localparam int MAXLEN = 32;

    typedef struct packed {
        logic [2:0]  st;
        logic [7:0]  dec;
        logic [31:0] cv;
        logic [5:0]  cl;
        logic [8:0]  ds;
    } outcome_t;

    outcome_t expected_q[$];

    int          hist[NSYM];
    int          weight[NNODE];
    int          left_child[NNODE];
    int          right_child[NNODE];
    int          leaf_sym[NSYM];
    logic [31:0] tab_code[NSYM];
    int          tab_len[NSYM];
    int          walk_node;
    int          root_node;
    int          leaf_count;
    bit          have_tree;
    bit          alive[NNODE];

    function automatic int pop_lightest(int total);
        int best;
        bit found;
        best = 0;
        found = 0;
        for (int i = 0; i < total; i++)
            if (alive[i] && (!found || weight[i] < weight[best]))
            begin
                best = i;
                found = 1;
            end
        alive[best] = 0;
        return best;
    endfunction

    function automatic void assign_codes(int nd, logic [31:0] code, int len);
        if (nd < leaf_count)
        begin
            if (len >= 1 && len <= MAXLEN)
            begin
                tab_code[leaf_sym[nd]] = code;
                tab_len[leaf_sym[nd]] = len;
            end
            return;
        end
        if (left_child[nd] != NONE)
            assign_codes(left_child[nd], code << 1, len + 1);
        if (right_child[nd] != NONE)
            assign_codes(right_child[nd], (code << 1) | 32'd1, len + 1);
    endfunction

    function automatic outcome_t build_codes();
        outcome_t r;
        int n;
        int total;
        int a;
        int b;
        r = '0;
        n = 0;
        for (int s = 0; s < NSYM; s++)
        begin
            tab_code[s] = '0;
            tab_len[s] = 0;
        end
        for (int s = 0; s < NSYM; s++)
            if (hist[s] != 0)
            begin
                weight[n] = hist[s];
                left_child[n] = NONE;
                right_child[n] = NONE;
                leaf_sym[n] = s;
                n++;
            end
        leaf_count = n;
        if (n == 0)
        begin
            have_tree = 0;
            walk_node = 0;
            root_node = 0;
            r.st = ST_NO_TREE;
            return r;
        end
        if (n == 1)
        begin
            weight[1] = weight[0];
            left_child[1] = 0;
            right_child[1] = NONE;
            root_node = 1;
        end
        else
        begin
            for (int i = 0; i < NNODE; i++)
                alive[i] = (i < n);
            total = n;
            for (int m = 0; m + 1 < n; m++)
            begin
                a = pop_lightest(total);
                b = pop_lightest(total);
                weight[total] = weight[a] + weight[b];
                left_child[total] = a;
                right_child[total] = b;
                alive[total] = 1;
                total++;
            end
            root_node = total - 1;
        end
        assign_codes(root_node, '0, 0);
        walk_node = root_node;
        have_tree = 1;
        r.st = ST_OK;
        r.ds = 9'(n);
        return r;
    endfunction

    function automatic outcome_t predict(logic [2:0] op, logic [7:0] sym, logic bit_in);
        outcome_t r;
        int nxt;
        r = '0;
        r.st = ST_OK;
        case (op)
            OP_CLEAR:
                for (int s = 0; s < NSYM; s++)
                    hist[s] = 0;
            OP_COUNT:
                if (hist[sym] >= LIMIT)
                    r.st = ST_OVERFLOW;
                else
                    hist[sym]++;
            OP_BUILD:
                r = build_codes();
            OP_ENCODE:
                if (!have_tree)
                    r.st = ST_NO_TREE;
                else if (tab_len[sym] == 0)
                    r.st = ST_UNKNOWN;
                else
                begin
                    r.cv = tab_code[sym];
                    r.cl = 6'(tab_len[sym]);
                end
            OP_DECODE:
                if (!have_tree)
                    r.st = ST_NO_TREE;
                else
                begin
                    nxt = bit_in ? right_child[walk_node] : left_child[walk_node];
                    if (nxt == NONE)
                    begin
                        r.st = ST_BAD_WALK;
                        walk_node = root_node;
                    end
                    else if (nxt < leaf_count)
                    begin
                        r.st = ST_DECODED;
                        r.dec = 8'(leaf_sym[nxt]);
                        walk_node = root_node;
                    end
                    else
                        walk_node = nxt;
                end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("MISMATCH result %0d: %s got %0d expected %0d", checked, field, got, want);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        checked = 0;
        pending = 0;
        for (int s = 0; s < NSYM; s++)
        begin
            hist[s] = 0;
            tab_code[s] = '0;
            tab_len[s] = 0;
        end
        walk_node = 0;
        root_node = 0;
        leaf_count = 0;
        have_tree = 0;
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                    report("done with no transfer outstanding", 1, 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (status !== want.st)
                        report("status", status, want.st);
                    if (decoded_symbol !== want.dec)
                        report("decoded_symbol", decoded_symbol, want.dec);
                    if (code_value !== want.cv)
                        report("code_value", code_value, want.cv);
                    if (code_length !== want.cl)
                        report("code_length", code_length, want.cl);
                    if (distinct_symbols !== want.ds)
                        report("distinct_symbols", distinct_symbols, want.ds);
                    checked++;
                end
            end
            if (start && !busy)
                expected_q.push_back(predict(operation, symbol, code_bit));
            pending = expected_q.size();
        end
    end
endmodule
`default_nettype wire

// ----- tb/tb_huffman_code_builder_codec.sv -----
// Testbench top for huffman_code_builder_codec: clock, reset, stimulus and verdict.
// Depends on hcb_pkg, the block and hcb_result_checker.
`default_nettype none
module tb_huffman_code_builder_codec
    import hcb_pkg::*;
;
    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic [2:0]  operation;
    logic [7:0]  symbol;
    logic        code_bit;
    logic [2:0]  status;
    logic [7:0]  decoded_symbol;
    logic [31:0] code_value;
    logic [5:0]  code_length;
    logic [8:0]  distinct_symbols;
    int          errors;
    int          checked;
    int          pending;
    int          sent;
    int          idle_pct;
    logic [7:0]  pool[16];
    int          pool_n;

    huffman_code_builder_codec dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .operation(operation), .symbol(symbol), .code_bit(code_bit),
        .status(status), .decoded_symbol(decoded_symbol), .code_value(code_value),
        .code_length(code_length), .distinct_symbols(distinct_symbols)
    );

    hcb_result_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .operation(operation), .symbol(symbol), .code_bit(code_bit),
        .status(status), .decoded_symbol(decoded_symbol), .code_value(code_value),
        .code_length(code_length), .distinct_symbols(distinct_symbols),
        .errors(errors), .checked(checked), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Issue one transfer; return right after the edge that accepts it.
    task automatic issue(logic [2:0] op, logic [7:0] sym, logic b);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        symbol <= sym;
        code_bit <= b;
        do
            @(posedge clk);
        while (busy);
        sent++;
    endtask

    task automatic decode_bits(int n);
        for (int i = 0; i < n; i++)
            issue(OP_DECODE, 8'($urandom), 1'($urandom));
    endtask

    // One session: maybe clear, fill the histogram, build, then encode and decode, with an occasional random operation.
    task automatic session(int max_distinct);
        pool_n = $urandom_range(max_distinct, 1);
        for (int i = 0; i < pool_n; i++)
            pool[i] = 8'($urandom);
        if ($urandom_range(3) != 0)
            issue(OP_CLEAR, 8'($urandom), 1'($urandom));
        repeat ($urandom_range(3 * pool_n, pool_n))
            issue(OP_COUNT, pool[$urandom_range(pool_n - 1)], 1'($urandom));
        issue(OP_BUILD, 8'($urandom), 1'($urandom));
        repeat ($urandom_range(12, 4))
        begin
            case ($urandom_range(9))
                0: issue(3'($urandom), 8'($urandom), 1'($urandom));
                1, 2, 3: issue(OP_ENCODE, pool[$urandom_range(pool_n - 1)], 1'($urandom));
                4: issue(OP_ENCODE, 8'($urandom), 1'($urandom));
                default: decode_bits($urandom_range(6, 1));
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_CLEAR;
        symbol = '0;
        code_bit = 1'b0;
        sent = 0;
        idle_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: no tree, empty build, single symbol, extremes, unused codes
        issue(OP_ENCODE, 8'd0, 1'b0);
        issue(OP_DECODE, 8'd0, 1'b1);
        issue(OP_BUILD, 8'd0, 1'b0);
        issue(OP_COUNT, 8'd0, 1'b0);
        issue(OP_BUILD, 8'hff, 1'b1);
        issue(OP_ENCODE, 8'd0, 1'b0);
        issue(OP_ENCODE, 8'd5, 1'b0);
        issue(OP_DECODE, 8'd0, 1'b0);
        issue(OP_DECODE, 8'd0, 1'b1);
        issue(OP_COUNT, 8'hff, 1'b0);
        issue(OP_COUNT, 8'h80, 1'b1);
        issue(OP_COUNT, 8'h80, 1'b0);
        issue(OP_BUILD, 8'd0, 1'b0);
        issue(OP_ENCODE, 8'hff, 1'b0);
        issue(OP_ENCODE, 8'h80, 1'b1);
        issue(OP_ENCODE, 8'd0, 1'b0);
        decode_bits(4);
        issue(3'd5, 8'hff, 1'b1);
        issue(3'd6, 8'h00, 1'b0);
        issue(3'd7, 8'haa, 1'b1);
        issue(OP_CLEAR, 8'd0, 1'b0);
        issue(OP_ENCODE, 8'h80, 1'b0);

        // full alphabet, one long build
        issue(OP_CLEAR, 8'd0, 1'b0);
        for (int s = 0; s < 256; s++)
            repeat ((s % 5 == 0) ? 2 : 1) issue(OP_COUNT, 8'(s), 1'b0);
        issue(OP_BUILD, 8'd0, 1'b0);
        repeat (20) issue(OP_ENCODE, 8'($urandom), 1'b0);
        decode_bits(40);

        sent = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 34 : (ph == 1) ? 76 : 0;
            while (sent < 100 * (ph + 1))
            begin
                if ($urandom_range(9) == 0)
                    issue(3'($urandom), 8'($urandom), 1'($urandom));
                else
                    session(12);
            end
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Covered directed cases, a full-alphabet build and");
        $display("%0d random transfers in sessions; %0d results checked.", sent, checked);
        if (errors == 0)
            $display("huffman_code_builder_codec regression: pass");
        else
            $display("huffman_code_builder_codec regression: fail");
        $finish;
    end

    initial
    begin
        #200000000;
        $display("huffman_code_builder_codec regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
